// ===== src/lpc_pkg.sv =====
// Shared types, constants and CORDIC step function for the polar-to-Cartesian converter.
package lpc_pkg;

  localparam int DEF_ANGLE_BITS = 16;
  localparam int DEF_RANGE_BITS = 18;
  localparam int LASER_W        = 6;
  localparam int REV_W          = 16;
  localparam int INTENSITY_W    = 8;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 32;
  localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sh26DD3B6A;
  localparam logic signed [63:0]         HALF_Q30    = 64'sd536870912;

  localparam logic [CORDIC_W-1:0] ATAN_TBL [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  typedef struct packed {
    logic                       neg;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] t;
  } cordic_t;

  // one rotation; sh is a constant at every call site
  function automatic cordic_t cordic_rotate(cordic_t c, int unsigned sh);
    cordic_t                    r;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [CORDIC_W-1:0] ang;
    logic signed [CORDIC_W-1:0] cx;
    logic signed [CORDIC_W-1:0] cy;
    cx  = c.x;
    cy  = c.y;
    xs  = cx >>> sh;
    ys  = cy >>> sh;
    ang = $signed(ATAN_TBL[sh[STEP_IDX_W-1:0]]);
    r.neg = c.neg;
    if (!c.t[CORDIC_W-1]) begin
      r.x = cx - ys;
      r.y = cy + xs;
      r.t = c.t - ang;
    end else begin
      r.x = cx + ys;
      r.y = cy - xs;
      r.t = c.t + ang;
    end
    return r;
  endfunction

endpackage

// ===== src/lidar_polar_to_cartesian_top.sv =====
// Top level of the lidar polar-to-Cartesian converter.
// Converts one return (range, pitch, heading) per clock into x, y, z in 1/1024 m,
// clamped to +-(2^RANGE_BITS - 1); laser, heading, revolution and intensity ride along.
// One transaction per cycle while out_stall is low. The pipe has one angle-fold stage,
// a row of 30 CORDIC cells (one rotation each, pitch and heading side by side) and five
// back-end stages (sign fix, direction products, rounding, range multiply, round/clamp).
// Every stage has its own valid bit, so bubbles close up and a stalled output only backs
// up the input once all 36 stages hold a transaction.
module lidar_polar_to_cartesian_top #(
  parameter int ANGLE_BITS = lpc_pkg::DEF_ANGLE_BITS,
  parameter int RANGE_BITS = lpc_pkg::DEF_RANGE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [RANGE_BITS-1:0]              in_range_dist,
  input  logic signed [ANGLE_BITS-1:0]       in_pitch_angle,
  input  logic [ANGLE_BITS-1:0]              in_heading_angle,
  input  logic [lpc_pkg::LASER_W-1:0]        in_laser_index,
  input  logic [lpc_pkg::REV_W-1:0]          in_rev_tag,
  input  logic [lpc_pkg::INTENSITY_W-1:0]    in_return_intensity,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [RANGE_BITS:0]         out_x_pos,
  output logic signed [RANGE_BITS:0]         out_y_pos,
  output logic signed [RANGE_BITS:0]         out_z_pos,
  output logic [lpc_pkg::LASER_W-1:0]        out_laser_out,
  output logic [ANGLE_BITS-1:0]              out_heading_out,
  output logic [lpc_pkg::REV_W-1:0]          out_rev_out,
  output logic [lpc_pkg::INTENSITY_W-1:0]    out_intensity_out
);
  import lpc_pkg::*;

  localparam int SIDE_W = RANGE_BITS + ANGLE_BITS + LASER_W + REV_W + INTENSITY_W;
  localparam logic signed [RANGE_BITS:0] OUT_MIN = {1'b1, {RANGE_BITS{1'b0}}};

  logic              fold_ready;
  logic [SIDE_W-1:0] in_side;
  logic [SIDE_W-1:0] out_side;

  logic              c_valid [CORDIC_STEPS+1];
  logic              c_ready [CORDIC_STEPS+1];
  cordic_t           c_p     [CORDIC_STEPS+1];
  cordic_t           c_h     [CORDIC_STEPS+1];
  logic [SIDE_W-1:0] c_side  [CORDIC_STEPS+1];

  assign in_side  = {in_range_dist, in_heading_angle, in_laser_index, in_rev_tag,
                     in_return_intensity};
  assign in_stall = !fold_ready;

  lpc_fold #(
    .ANGLE_BITS (ANGLE_BITS),
    .SIDE_W     (SIDE_W)
  ) u_fold (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_valid),
    .up_ready   (fold_ready),
    .up_pitch   (in_pitch_angle),
    .up_heading (in_heading_angle),
    .up_side    (in_side),
    .dn_valid   (c_valid[0]),
    .dn_ready   (c_ready[0]),
    .dn_p       (c_p[0]),
    .dn_h       (c_h[0]),
    .dn_side    (c_side[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    lpc_cordic_cell #(
      .STEP   (i),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_valid[i]),
      .up_ready (c_ready[i]),
      .up_p     (c_p[i]),
      .up_h     (c_h[i]),
      .up_side  (c_side[i]),
      .dn_valid (c_valid[i+1]),
      .dn_ready (c_ready[i+1]),
      .dn_p     (c_p[i+1]),
      .dn_h     (c_h[i+1]),
      .dn_side  (c_side[i+1])
    );
  end

  lpc_scale #(
    .RANGE_BITS (RANGE_BITS),
    .SIDE_W     (SIDE_W)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c_valid[CORDIC_STEPS]),
    .up_ready (c_ready[CORDIC_STEPS]),
    .up_p     (c_p[CORDIC_STEPS]),
    .up_h     (c_h[CORDIC_STEPS]),
    .up_side  (c_side[CORDIC_STEPS]),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .dn_x     (out_x_pos),
    .dn_y     (out_y_pos),
    .dn_z     (out_z_pos),
    .dn_side  (out_side)
  );

  assign {out_heading_out, out_laser_out, out_rev_out, out_intensity_out} =
    out_side[SIDE_W-RANGE_BITS-1:0];

  // input backs up only when the whole pipe is full behind a stalled output
  a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output side is free");

  // clamp is symmetric: the most negative code never appears
  a_clamp_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_x_pos != OUT_MIN && out_y_pos != OUT_MIN && out_z_pos != OUT_MIN))
    else $error("coordinate outside symmetric clamp range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

// ===== src/lpc_fold.sv =====
// Input stage: widens both angles to a 32-bit turn fraction and folds them into +-1/4 turn.
module lpc_fold #(
  parameter int ANGLE_BITS = lpc_pkg::DEF_ANGLE_BITS,
  parameter int SIDE_W     = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [ANGLE_BITS-1:0] up_pitch,
  input  logic [ANGLE_BITS-1:0] up_heading,
  input  logic [SIDE_W-1:0]     up_side,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output lpc_pkg::cordic_t      dn_p,
  output lpc_pkg::cordic_t      dn_h,
  output logic [SIDE_W-1:0]     dn_side
);
  import lpc_pkg::*;

  localparam logic signed [CORDIC_W:0] QUARTER = 33'sh040000000;
  localparam logic signed [CORDIC_W:0] HALF    = 33'sh080000000;

  function automatic cordic_t fold(logic [ANGLE_BITS-1:0] a);
    cordic_t                  c;
    logic [CORDIC_W-1:0]      a32;
    logic signed [CORDIC_W:0] ts;
    a32   = {a, {(CORDIC_W-ANGLE_BITS){1'b0}}};
    ts    = $signed({a32[CORDIC_W-1], a32});
    c.neg = 1'b0;
    if (ts > QUARTER) begin
      ts    = ts - HALF;
      c.neg = 1'b1;
    end else if (ts < -QUARTER) begin
      ts    = ts + HALF;
      c.neg = 1'b1;
    end
    c.x = CORDIC_GAIN;
    c.y = '0;
    c.t = ts[CORDIC_W-1:0];
    return c;
  endfunction

  logic              v_r;
  cordic_t           p_r;
  cordic_t           h_r;
  logic [SIDE_W-1:0] side_r;
  logic              ld;

  assign up_ready = !v_r || dn_ready;
  assign ld       = up_ready && up_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
    if (ld) begin
      p_r    <= fold(up_pitch);
      h_r    <= fold(up_heading);
      side_r <= up_side;
    end
  end

  assign dn_valid = v_r;
  assign dn_p     = p_r;
  assign dn_h     = h_r;
  assign dn_side  = side_r;

endmodule

// ===== src/lpc_cordic_cell.sv =====
// One CORDIC cell: a single rotation step for pitch and heading, with a holding register.
module lpc_cordic_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  lpc_pkg::cordic_t  up_p,
  input  lpc_pkg::cordic_t  up_h,
  input  logic [SIDE_W-1:0] up_side,
  output logic              dn_valid,
  input  logic              dn_ready,
  output lpc_pkg::cordic_t  dn_p,
  output lpc_pkg::cordic_t  dn_h,
  output logic [SIDE_W-1:0] dn_side
);
  import lpc_pkg::*;

  logic              v_r;
  cordic_t           p_r;
  cordic_t           h_r;
  logic [SIDE_W-1:0] side_r;
  logic              ld;

  assign up_ready = !v_r || dn_ready;
  assign ld       = up_ready && up_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
    if (ld) begin
      p_r    <= cordic_rotate(up_p, STEP);
      h_r    <= cordic_rotate(up_h, STEP);
      side_r <= up_side;
    end
  end

  assign dn_valid = v_r;
  assign dn_p     = p_r;
  assign dn_h     = h_r;
  assign dn_side  = side_r;

endmodule

// ===== src/lpc_scale.sv =====
// Back end: sign fix, direction products, range scaling, rounding and clamping in five stages.
module lpc_scale #(
  parameter int RANGE_BITS = lpc_pkg::DEF_RANGE_BITS,
  parameter int SIDE_W     = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  lpc_pkg::cordic_t             up_p,
  input  lpc_pkg::cordic_t             up_h,
  input  logic [SIDE_W-1:0]            up_side,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic signed [RANGE_BITS:0]   dn_x,
  output logic signed [RANGE_BITS:0]   dn_y,
  output logic signed [RANGE_BITS:0]   dn_z,
  output logic [SIDE_W-1:0]            dn_side
);
  import lpc_pkg::*;

  localparam int NS = 5;
  localparam int CW = CORDIC_W;
  localparam int DW = CW + 1;
  localparam int PW = RANGE_BITS + 1 + DW;
  localparam int RW = PW - 30;

  localparam logic signed [PW-1:0] HALF_P = PW'(HALF_Q30);
  localparam logic signed [RW-1:0] LIM    = {{(RW-RANGE_BITS){1'b0}}, {RANGE_BITS{1'b1}}};

  function automatic logic signed [RANGE_BITS:0] round_clamp(logic signed [PW-1:0] m);
    logic signed [PW-1:0] t;
    logic signed [RW-1:0] r;
    t = m + HALF_P;
    r = t[PW-1:30];
    if (r > LIM) begin
      r = LIM;
    end else if (r < -LIM) begin
      r = -LIM;
    end
    return r[RANGE_BITS:0];
  endfunction

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS-1:0] rdy;
  logic [NS-1:0] ld;

  logic signed [CW-1:0]         cp_r, sp_r, ch_r, sh_r;
  logic signed [2*CW-1:0]       pc_r, ps_r;
  logic signed [CW-1:0]         sp1_r;
  logic signed [DW-1:0]         cxy_r, sxy_r, sz_r;
  logic signed [PW-1:0]         mx_r, my_r, mz_r;
  logic signed [RANGE_BITS:0]   x_r, y_r, z_r;
  logic [SIDE_W-1:0]            side_r [NS];

  logic signed [2*CW-1:0]       pc_rnd, ps_rnd;
  logic signed [RANGE_BITS:0]   rng_s;

  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || dn_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    ld[0]    = rdy[0] && up_valid;
    v_nxt[0] = rdy[0] ? up_valid : v_r[0];
    for (int k = 1; k < NS; k++) begin
      ld[k]    = rdy[k] && v_r[k-1];
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  assign pc_rnd = pc_r + HALF_Q30;
  assign ps_rnd = ps_r + HALF_Q30;
  assign rng_s  = $signed({1'b0, side_r[2][SIDE_W-1 -: RANGE_BITS]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
    if (ld[0]) begin
      cp_r      <= up_p.neg ? -up_p.x : up_p.x;
      sp_r      <= up_p.neg ? -up_p.y : up_p.y;
      ch_r      <= up_h.neg ? -up_h.x : up_h.x;
      sh_r      <= up_h.neg ? -up_h.y : up_h.y;
      side_r[0] <= up_side;
    end
    if (ld[1]) begin
      pc_r      <= cp_r * ch_r;
      ps_r      <= cp_r * sh_r;
      sp1_r     <= sp_r;
      side_r[1] <= side_r[0];
    end
    if (ld[2]) begin
      cxy_r     <= pc_rnd[30+DW-1:30];
      sxy_r     <= ps_rnd[30+DW-1:30];
      sz_r      <= DW'(sp1_r);
      side_r[2] <= side_r[1];
    end
    if (ld[3]) begin
      mx_r      <= rng_s * cxy_r;
      my_r      <= rng_s * sxy_r;
      mz_r      <= rng_s * sz_r;
      side_r[3] <= side_r[2];
    end
    if (ld[4]) begin
      x_r       <= round_clamp(mx_r);
      y_r       <= round_clamp(my_r);
      z_r       <= round_clamp(mz_r);
      side_r[4] <= side_r[3];
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[NS-1];
  assign dn_x     = x_r;
  assign dn_y     = y_r;
  assign dn_z     = z_r;
  assign dn_side  = side_r[NS-1];

endmodule
